// File: design/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg
// types and constants shared by the binary min-heap queue modules
// ----------------------------------------------------------------------------
package bmh_pkg;

    localparam int DEPTH     = 1024;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_DEC    = 2'd2,
        CMD_INC    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_SLOT    = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]           command;
        logic signed [31:0]   key_value;
        logic [9:0]           slot_index;
    } req_t;

    typedef struct packed {
        logic signed [31:0]   result_key;
        logic [2:0]           status;
        logic [10:0]          occupancy;
    } rsp_t;

    // memory port bundle from controller to ram
    typedef struct packed {
        logic                 wr_en;
        logic [ADDR_W-1:0]    wr_addr;
        logic [KEY_WIDTH-1:0] wr_data;
        logic [ADDR_W-1:0]    rd_addr_a;
        logic [ADDR_W-1:0]    rd_addr_b;
    } mem_req_t;

endpackage

// File: design/bmh_ram.sv
// ----------------------------------------------------------------------------
// bmh_ram
// key store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module bmh_ram
    import bmh_pkg::*;
(
    input  logic                 aclk,
    input  mem_req_t             mreq,
    output logic [KEY_WIDTH-1:0] rd_data_a,
    output logic [KEY_WIDTH-1:0] rd_data_b
);

    logic [KEY_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (mreq.wr_en) begin
            mem[mreq.wr_addr] <= mreq.wr_data;
        end
        rd_data_a <= mem[mreq.rd_addr_a];
        rd_data_b <= mem[mreq.rd_addr_b];
    end

endmodule

// File: design/bmh_ctrl.sv
// ----------------------------------------------------------------------------
// bmh_ctrl
// command sequencer: sift up and sift down over the key store
// ----------------------------------------------------------------------------
module bmh_ctrl
    import bmh_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    output mem_req_t             mreq,
    input  logic [KEY_WIDTH-1:0] rd_data_a,
    input  logic [KEY_WIDTH-1:0] rd_data_b
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHK   = 7'b0000010,
        S_UPRD  = 7'b0000100,
        S_UPCMP = 7'b0001000,
        S_DNRD  = 7'b0010000,
        S_DNCMP = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ADDR_W-1:0]        pos_reg, pos_next;
    logic signed [KEY_WIDTH-1:0] key_reg, key_next;
    logic [1:0]               cmd_reg, cmd_next;
    logic signed [KEY_WIDTH-1:0] res_key_reg, res_key_next;
    logic [2:0]               status_reg, status_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    rsp_t                     rsp_reg, rsp_next;

    logic signed [KEY_WIDTH-1:0] da, db;
    logic [ADDR_W:0]          lchild, rchild;
    logic [ADDR_W-1:0]        parent;

    assign da     = rd_data_a;
    assign db     = rd_data_b;
    assign parent = ADDR_W'((pos_reg - 1'b1) >> 1);
    assign lchild = {pos_reg, 1'b1};
    assign rchild = {pos_reg, 1'b0} + (ADDR_W+1)'(2);

    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        cmd_next       = cmd_reg;
        res_key_next   = res_key_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mreq           = '0;
        mreq.rd_addr_a = pos_reg;
        mreq.rd_addr_b = pos_reg;

        if (rsp_valid_reg && rsp_ready) begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (req_valid && req_ready) begin
                    cmd_next     = req.command;
                    key_next     = req.key_value;
                    res_key_next = '0;
                    status_next  = ST_DONE;
                    state_next   = S_FIN;
                    case (cmd_t'(req.command))
                        CMD_INSERT: begin
                            if (count_reg >= CNT_W'(DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                pos_next   = ADDR_W'(count_reg);
                                count_next = count_reg + 1'b1;
                                state_next = S_UPRD;
                            end
                        end
                        CMD_POP: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                // root into a, last entry into b
                                mreq.rd_addr_a = '0;
                                mreq.rd_addr_b = ADDR_W'(count_reg - 1'b1);
                                count_next     = count_reg - 1'b1;
                                pos_next       = '0;
                                state_next     = S_CHK;
                            end
                        end
                        default: begin
                            if (CNT_W'(req.slot_index) >= count_reg) begin
                                status_next = ST_SLOT;
                            end else begin
                                mreq.rd_addr_a = req.slot_index;
                                pos_next       = req.slot_index;
                                state_next     = S_CHK;
                            end
                        end
                    endcase
                end
            end
            S_CHK: begin
                if (cmd_reg == CMD_POP) begin
                    res_key_next = da;
                    key_next     = db;
                    state_next   = S_DNRD;
                end else if (cmd_reg == CMD_DEC) begin
                    if (key_reg >= da) begin
                        status_next = ST_IGNORED;
                        state_next  = S_FIN;
                    end else begin
                        state_next = S_UPRD;
                    end
                end else begin
                    if (key_reg <= da) begin
                        status_next = ST_IGNORED;
                        state_next  = S_FIN;
                    end else begin
                        state_next = S_DNRD;
                    end
                end
            end
            // hole at pos_reg, key_reg travels; written when it settles
            S_UPRD: begin
                if (pos_reg == '0) begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = pos_reg;
                    mreq.wr_data = key_reg;
                    state_next   = S_FIN;
                end else begin
                    mreq.rd_addr_a = parent;
                    state_next     = S_UPCMP;
                end
            end
            S_UPCMP: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = pos_reg;
                if (da > key_reg) begin
                    mreq.wr_data = da;
                    pos_next     = parent;
                    state_next   = S_UPRD;
                end else begin
                    mreq.wr_data = key_reg;
                    state_next   = S_FIN;
                end
            end
            S_DNRD: begin
                if (count_reg == '0) begin
                    state_next = S_FIN;
                end else if (lchild >= (ADDR_W+1)'(count_reg)) begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = pos_reg;
                    mreq.wr_data = key_reg;
                    state_next   = S_FIN;
                end else begin
                    mreq.rd_addr_a = ADDR_W'(lchild);
                    mreq.rd_addr_b = ADDR_W'(rchild);
                    state_next     = S_DNCMP;
                end
            end
            S_DNCMP: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = pos_reg;
                if (rchild < (ADDR_W+1)'(count_reg) && db < da && db < key_reg) begin
                    mreq.wr_data = db;
                    pos_next     = ADDR_W'(rchild);
                    state_next   = S_DNRD;
                end else if (da < key_reg) begin
                    mreq.wr_data = da;
                    pos_next     = ADDR_W'(lchild);
                    state_next   = S_DNRD;
                end else begin
                    mreq.wr_data = key_reg;
                    state_next   = S_FIN;
                end
            end
            S_FIN: begin
                if (!rsp_valid_reg) begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.result_key  = res_key_reg;
                    rsp_next.status      = status_reg;
                    rsp_next.occupancy   = 11'(count_reg);
                    state_next           = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
        pos_reg     <= pos_next;
        key_reg     <= key_next;
        cmd_reg     <= cmd_next;
        res_key_reg <= res_key_next;
        status_reg  <= status_next;
        rsp_reg     <= rsp_next;
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH)) else $error("count over depth");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !req_ready) else $error("ready while busy");
    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |=> $stable(count_reg)) else $error("count moved");
    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mreq.wr_en |-> (state_reg != S_IDLE)) else $error("write while idle");
`endif

endmodule

// File: design/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// zero-indexed binary min-heap priority queue over a key memory
// ----------------------------------------------------------------------------
// channel  | ports             | payload
// request  | s_valid, s_ready  | s_data (command, key_value, slot_index)
// result   | m_valid, m_ready  | m_data (result_key, status, occupancy)
//
// one request at a time; a rejected request or an ignored key change returns
// without a walk, others move the key one level at a time up or down the heap.
// each level of the walk waits on a registered read of the key memory; sifting down reads both children together.
// aresetn is synchronous and clears the entry count; memory is not cleared.
// a stalled result holds in its output register until m_ready.
// ----------------------------------------------------------------------------
module binary_min_heap_queue
    import bmh_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    mem_req_t             mreq;
    logic [KEY_WIDTH-1:0] rd_data_a, rd_data_b;

    bmh_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_data),
        .rsp_valid (m_valid),
        .rsp_ready (m_ready),
        .rsp       (m_data),
        .mreq      (mreq),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    bmh_ram u_ram (
        .aclk      (aclk),
        .mreq      (mreq),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

endmodule
